// ----- sv/sj2iso_pkg.sv -----
`default_nettype none

package sj2iso_pkg;

    localparam int unsigned MaxBytes = 6;
    localparam int unsigned IdxW     = 3;

    // control and shift codes
    localparam logic [7:0] EscByte    = 8'h1b;
    localparam logic [7:0] SoByte     = 8'h0e;
    localparam logic [7:0] SiByte     = 8'h0f;
    localparam logic [7:0] ParenByte  = 8'h28;
    localparam logic [7:0] RomanByte  = 8'h4a;
    localparam logic [7:0] DollarByte = 8'h24;
    localparam logic [7:0] KanjiBByte = 8'h42;

    // Shift_JIS class boundaries and JIS offsets
    localparam logic [7:0] KanaLo    = 8'ha0;
    localparam logic [7:0] KanaHi    = 8'hdf;
    localparam logic [7:0] TrailSplit = 8'h9f;
    localparam logic [7:0] TrailHi   = 8'h7f;
    localparam logic [7:0] RowLowOfs = 8'h1f;   // (lead - 0x81) * 2 + 0x21, mod 256
    localparam logic [7:0] RowHiOfs  = 8'h9f;   // (lead - 0xe0) * 2 + 0x5f, mod 256
    localparam logic [7:0] ColHiOfs  = 8'h20;
    localparam logic [7:0] ColLoOfs  = 8'h1f;
    localparam logic [7:0] ColOddOfs = 8'h7e;
    localparam logic [7:0] KanaOfs   = 8'h80;

    typedef struct packed {
        logic       kanji_mode;
        logic       kana_shifted;
        logic       lead_pending;
        logic [7:0] lead_byte;
    } conv_state_t;

    typedef struct packed {
        logic                         load;
        logic [IdxW-1:0]              last_idx;
        logic [MaxBytes-1:0][7:0]     bytes;
    } burst_t;

endpackage

`default_nettype wire

// ----- sv/sj2iso_in_if.sv -----
`default_nettype none

interface sj2iso_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/sj2iso_out_if.sv -----
`default_nettype none

interface sj2iso_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/shift_jis_to_iso2022jp_unit.sv -----
`default_nettype none

// channel  dir  payload                  meaning
// din      in   data_byte[7:0]           one shift_jis byte a beat
// dout     out  out_byte[7:0], last      one iso-2022-jp byte a beat, last ends a burst
//
// one input beat is taken per cycle while the burst register can take a new burst
// a lead byte gives no output but still waits until the burst register is free; any
// other byte yields a burst of 1 to 6 output beats, sent one per cycle while dout is ready
// the next input is taken in the same cycle as the last beat of the current burst
// reset clears the mode, kana shift, pending lead and the burst valid flag

module shift_jis_to_iso2022jp_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sj2iso_in_if.sink    din,
    sj2iso_out_if.source dout
);
    import sj2iso_pkg::*;

    conv_state_t state_reg;
    conv_state_t state_next;
    burst_t      burst;
    logic        can_load;
    logic        take;

    // input is accepted whenever the burst register is free or draining its last beat
    assign din.ready = can_load;
    assign take      = din.valid && can_load;

    // converter state and byte classification
    sj2iso_decode u_decode (
        .cur       (state_reg),
        .data_byte (din.data_byte),
        .nxt       (state_next),
        .burst     (burst)
    );

    // mode, kana shift and pending lead move only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

    // burst register and serialiser towards the output channel
    sj2iso_burst u_burst (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .burst    (burst),
        .can_load (can_load),
        .dout     (dout)
    );

endmodule

`default_nettype wire

// ----- sv/sj2iso_decode.sv -----
`default_nettype none

module sj2iso_decode (
    input  wire  sj2iso_pkg::conv_state_t cur,
    input  wire  logic [7:0]              data_byte,
    output sj2iso_pkg::conv_state_t       nxt,
    output sj2iso_pkg::burst_t            burst
);
    import sj2iso_pkg::*;

    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] lead2;
    logic       odd_trail;

    // jis row and column from the held lead and this trail
    always_comb
    begin
        lead2     = {cur.lead_byte[6:0], 1'b0};
        odd_trail = (data_byte >= TrailSplit);
        if (cur.lead_byte < KanaLo)
            row = lead2 + RowLowOfs + {7'd0, odd_trail};
        else
            row = lead2 + RowHiOfs + {7'd0, odd_trail};
        if (odd_trail)
            col = data_byte - ColOddOfs;
        else if (data_byte > TrailHi)
            col = data_byte - ColHiOfs;
        else
            col = data_byte - ColLoOfs;
    end

    always_comb
    begin
        nxt            = cur;
        burst.load     = 1'b1;
        burst.last_idx = '0;
        burst.bytes    = '0;
        if (cur.lead_pending)
        begin
            nxt.lead_pending = 1'b0;
            nxt.kana_shifted = 1'b0;
            nxt.kanji_mode   = 1'b1;
            if (cur.kana_shifted)
            begin
                burst.bytes[0] = SiByte;
                burst.bytes[1] = EscByte;
                burst.bytes[2] = DollarByte;
                burst.bytes[3] = KanjiBByte;
                burst.bytes[4] = row;
                burst.bytes[5] = col;
                burst.last_idx = IdxW'(5);
            end
            else if (!cur.kanji_mode)
            begin
                burst.bytes[0] = EscByte;
                burst.bytes[1] = DollarByte;
                burst.bytes[2] = KanjiBByte;
                burst.bytes[3] = row;
                burst.bytes[4] = col;
                burst.last_idx = IdxW'(4);
            end
            else
            begin
                burst.bytes[0] = row;
                burst.bytes[1] = col;
                burst.last_idx = IdxW'(1);
            end
        end
        else if (!data_byte[7])
        begin
            nxt.kana_shifted = 1'b0;
            nxt.kanji_mode   = 1'b0;
            if (cur.kana_shifted)
            begin
                burst.bytes[0] = SiByte;
                burst.bytes[1] = data_byte;
                burst.last_idx = IdxW'(1);
            end
            else if (cur.kanji_mode)
            begin
                burst.bytes[0] = EscByte;
                burst.bytes[1] = ParenByte;
                burst.bytes[2] = RomanByte;
                burst.bytes[3] = data_byte;
                burst.last_idx = IdxW'(3);
            end
            else
            begin
                burst.bytes[0] = data_byte;
            end
        end
        else if (data_byte >= KanaLo && data_byte <= KanaHi)
        begin
            if (cur.kana_shifted)
            begin
                burst.bytes[0] = data_byte - KanaOfs;
            end
            else
            begin
                nxt.kana_shifted = 1'b1;
                nxt.kanji_mode   = 1'b0;
                if (cur.kanji_mode)
                begin
                    burst.bytes[0] = EscByte;
                    burst.bytes[1] = ParenByte;
                    burst.bytes[2] = RomanByte;
                    burst.bytes[3] = SoByte;
                    burst.bytes[4] = data_byte - KanaOfs;
                    burst.last_idx = IdxW'(4);
                end
                else
                begin
                    burst.bytes[0] = SoByte;
                    burst.bytes[1] = data_byte - KanaOfs;
                    burst.last_idx = IdxW'(1);
                end
            end
        end
        else
        begin
            // lead byte is only held
            nxt.lead_pending = 1'b1;
            nxt.lead_byte    = data_byte;
            burst.load       = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sj2iso_burst.sv -----
`default_nettype none

module sj2iso_burst (
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  logic               take,
    input  wire  sj2iso_pkg::burst_t burst,
    output logic                     can_load,
    sj2iso_out_if.source             dout
);
    import sj2iso_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic [IdxW-1:0]          idx_reg;
    logic [IdxW-1:0]          idx_next;
    logic [IdxW-1:0]          last_idx_reg;
    logic [MaxBytes-1:0][7:0] bytes_reg;
    logic                     at_last;
    logic                     load;

    assign at_last  = (idx_reg == last_idx_reg);
    assign can_load = !valid_reg || (dout.ready && at_last);
    assign load     = take && burst.load;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (valid_reg && dout.ready)
        begin
            if (at_last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + IdxW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg    <= burst.bytes;
            last_idx_reg <= burst.last_idx;
        end
    end

    assign dout.valid    = valid_reg;
    assign dout.out_byte = bytes_reg[idx_reg];
    assign dout.last     = at_last;

endmodule

`default_nettype wire

// ----- tb/shift_jis_to_iso2022jp_unit_test.sv -----
module shift_jis_to_iso2022jp_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sj2iso_pkg::*;

    // lead byte bases and jis row bases for the two lead ranges
    localparam logic [7:0] LeadBaseLow  = 8'h81;
    localparam logic [7:0] LeadBaseHigh = 8'he0;
    localparam logic [7:0] RowBaseLow   = 8'h21;
    localparam logic [7:0] RowBaseHigh  = 8'h5f;
    localparam logic [7:0] AsciiTop     = 8'h7f;

    localparam int RandomItems = 350;
    localparam int TailCycles  = 16;
    localparam int CycleLimit  = 200_000;
    localparam int ReportMax   = 10;

    // one expected output beat
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } jis_beat_t;

    // one directed row: the byte sent and, where pinned, the burst typed in by hand
    // (burst bytes are right-aligned, first beat in the most significant used byte)
    typedef struct packed {
        logic [7:0]  data;
        logic        pinned;
        logic [2:0]  count;
        logic [47:0] burst;
    } stim_row_t;

    localparam int NumDirected = 25;

    stim_row_t directed_rows [NumDirected] = '{
        // plain ascii after reset, zero byte, top of ascii
        stim_row_t'{8'h41, 1'b1, 3'd1, 48'h41},
        stim_row_t'{8'h00, 1'b1, 3'd1, 48'h00},
        stim_row_t'{8'h7f, 1'b1, 3'd1, 48'h7f},
        // both ends of half-width kana: shift out once, then stay shifted
        stim_row_t'{8'ha0, 1'b1, 3'd2, 48'h0e20},
        stim_row_t'{8'hdf, 1'b1, 3'd1, 48'h5f},
        // ascii leaves kana with shift in
        stim_row_t'{8'h20, 1'b1, 3'd2, 48'h0f20},
        // first kanji pair from single-byte mode
        stim_row_t'{8'h81, 1'b1, 3'd0, 48'h0},
        stim_row_t'{8'h40, 1'b1, 3'd5, 48'h1b24422121},
        // ascii leaves kanji with esc ( J
        stim_row_t'{8'h0a, 1'b1, 3'd4, 48'h1b284a0a},
        // top lead with top trail
        stim_row_t'{8'hff, 1'b1, 3'd0, 48'h0},
        stim_row_t'{8'hff, 1'b0, 3'd0, 48'h0},
        // kana straight out of kanji
        stim_row_t'{8'hb1, 1'b1, 3'd5, 48'h1b284a0e31},
        // lead 0x80 from kana, zero byte as trail: the longest burst
        stim_row_t'{8'h80, 1'b1, 3'd0, 48'h0},
        stim_row_t'{8'h00, 1'b0, 3'd0, 48'h0},
        // pairs while already in kanji, around the trail split points
        stim_row_t'{8'h9f, 1'b1, 3'd0, 48'h0},
        stim_row_t'{8'h9f, 1'b0, 3'd0, 48'h0},
        stim_row_t'{8'he0, 1'b1, 3'd0, 48'h0},
        stim_row_t'{8'h7f, 1'b0, 3'd0, 48'h0},
        stim_row_t'{8'he0, 1'b1, 3'd0, 48'h0},
        stim_row_t'{8'h80, 1'b0, 3'd0, 48'h0},
        stim_row_t'{8'hfc, 1'b1, 3'd0, 48'h0},
        stim_row_t'{8'h9e, 1'b0, 3'd0, 48'h0},
        // a lead-valued byte taken as trail
        stim_row_t'{8'h81, 1'b1, 3'd0, 48'h0},
        stim_row_t'{8'h81, 1'b0, 3'd0, 48'h0},
        stim_row_t'{8'hc0, 1'b0, 3'd0, 48'h0}
    };

    logic clk = 1'b0;
    logic rst_n;

    sj2iso_in_if  din_ch ();
    sj2iso_out_if dout_ch ();

    shift_jis_to_iso2022jp_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch)
    );

    always
    begin
        #2ns clk = 1'b1;
        #2ns clk = 1'b0;
    end

    // converter state as the predictor sees it
    logic       in_kanji  = 1'b0;
    logic       in_kana   = 1'b0;
    logic       lead_held = 1'b0;
    logic [7:0] held_lead = 8'h00;

    jis_beat_t expected_beats [$];

    // random idling on both channels, switched off for quiet stretches
    logic gaps_on = 1'b1;

    int mismatches    = 0;
    int items_sent    = 0;
    int beats_seen    = 0;
    int kanji_pairs   = 0;
    int kana_bytes    = 0;
    int cycle_count   = 0;

    // iso-2022-jp bytes produced by one shift_jis byte, updating the mode state
    function automatic void translate_byte(input logic [7:0] b, output logic [7:0] seq [$]);
        logic [7:0] row;
        logic [7:0] col;
        seq.delete();
        if (lead_held)
        begin
            // anything after a held lead is its trail
            lead_held = 1'b0;
            kanji_pairs++;
            if (in_kana)
            begin
                seq.push_back(SiByte);
                in_kana  = 1'b0;
                in_kanji = 1'b0;
            end
            if (!in_kanji)
            begin
                seq.push_back(EscByte);
                seq.push_back(DollarByte);
                seq.push_back(KanjiBByte);
                in_kanji = 1'b1;
            end
            // 8-bit arithmetic keeps everything modulo 256
            if (b < TrailSplit)
            begin
                if (held_lead < KanaLo)
                    row = (held_lead - LeadBaseLow) * 8'd2 + RowBaseLow;
                else
                    row = (held_lead - LeadBaseHigh) * 8'd2 + RowBaseHigh;
                col = (b > TrailHi) ? b - ColHiOfs : b - ColLoOfs;
            end
            else
            begin
                if (held_lead < KanaLo)
                    row = (held_lead - LeadBaseLow) * 8'd2 + RowBaseLow + 8'd1;
                else
                    row = (held_lead - LeadBaseHigh) * 8'd2 + RowBaseHigh + 8'd1;
                col = b - ColOddOfs;
            end
            seq.push_back(row);
            seq.push_back(col);
        end
        else if (b <= AsciiTop)
        begin
            if (in_kana)
            begin
                seq.push_back(SiByte);
                in_kana  = 1'b0;
                in_kanji = 1'b0;
            end
            else if (in_kanji)
            begin
                seq.push_back(EscByte);
                seq.push_back(ParenByte);
                seq.push_back(RomanByte);
                in_kanji = 1'b0;
            end
            seq.push_back(b);
        end
        else if (b >= KanaLo && b <= KanaHi)
        begin
            kana_bytes++;
            if (!in_kana)
            begin
                if (in_kanji)
                begin
                    seq.push_back(EscByte);
                    seq.push_back(ParenByte);
                    seq.push_back(RomanByte);
                    in_kanji = 1'b0;
                end
                seq.push_back(SoByte);
                in_kana = 1'b1;
            end
            seq.push_back(b - KanaOfs);
        end
        else
        begin
            held_lead = b;
            lead_held = 1'b1;
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= ReportMax)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // drive one input beat, wait for it to be taken, then queue what it should cause
    task automatic send_byte(input logic [7:0] b, input logic pinned, input logic [2:0] count,
                             input logic [47:0] burst);
        logic [7:0] seq [$];
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            din_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_ch.valid     <= 1'b1;
        din_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!din_ch.ready);
        translate_byte(b, seq);
        // pinned rows replace the prediction by the hand-typed burst
        if (pinned)
        begin
            seq.delete();
            for (int i = 0; i < count; i++)
                seq.push_back(burst[8 * (count - 1 - i) +: 8]);
        end
        for (int i = 0; i < seq.size(); i++)
            expected_beats.push_back(jis_beat_t'{code: seq[i], last: (i == seq.size() - 1)});
        items_sent++;
    endtask

    // random well-formed lead and trail pair
    function automatic logic [7:0] pick_lead();
        if ($urandom_range(0, 1) == 1)
            return 8'($urandom_range(8'h81, 8'h9f));
        return 8'($urandom_range(8'he0, 8'hfc));
    endfunction

    function automatic logic [7:0] pick_trail();
        if ($urandom_range(0, 1) == 1)
            return 8'($urandom_range(8'h40, 8'h7e));
        return 8'($urandom_range(8'h80, 8'hfc));
    endfunction

    // output side: every accepted beat is checked against the oldest expectation
    always @(posedge clk)
    begin : out_check
        jis_beat_t want;
        if (rst_n && dout_ch.valid && dout_ch.ready)
        begin
            beats_seen++;
            if (expected_beats.size() == 0)
                note_mismatch($sformatf("unexpected beat out_byte=%02h last=%0b",
                                        dout_ch.out_byte, dout_ch.last));
            else
            begin
                want = expected_beats.pop_front();
                if (dout_ch.out_byte !== want.code || dout_ch.last !== want.last)
                    note_mismatch($sformatf("out_byte exp %02h got %02h, last exp %0b got %0b",
                                            want.code, dout_ch.out_byte,
                                            want.last, dout_ch.last));
            end
        end
    end

    // watchdog, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_beats.size());
            $display("** shift_jis_to_iso2022jp_unit: FAILED **");
            $finish;
        end
    end

    // sink: ready drops at random while idling is on
    initial
    begin
        dout_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                dout_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            dout_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        int random_count;
        int kind;
        int run;
        logic [7:0] b;

        rst_n            <= 1'b0;
        din_ch.valid     <= 1'b0;
        din_ch.data_byte <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: extremes, every mode change, the longest burst
        for (int r = 0; r < NumDirected; r++)
            send_byte(directed_rows[r].data, directed_rows[r].pinned,
                      directed_rows[r].count, directed_rows[r].burst);

        // random part: mostly well-formed runs, some noise and broken pairs
        random_count = 0;
        while (random_count < RandomItems)
        begin
            // a quiet stretch in the middle, and none at all near the end
            gaps_on = !((random_count >= 150 && random_count < 200) || random_count >= 290);
            kind = $urandom_range(0, 9);
            run  = $urandom_range(1, 4);
            if (kind <= 2)
            begin
                repeat (run)
                begin
                    send_byte(8'($urandom_range(0, 127)), 1'b0, 3'd0, 48'd0);
                    random_count++;
                end
            end
            else if (kind <= 4)
            begin
                repeat (run)
                begin
                    send_byte(8'($urandom_range(8'ha0, 8'hdf)), 1'b0, 3'd0, 48'd0);
                    random_count++;
                end
            end
            else if (kind <= 7)
            begin
                repeat ((run + 1) / 2 + 1)
                begin
                    send_byte(pick_lead(), 1'b0, 3'd0, 48'd0);
                    send_byte(pick_trail(), 1'b0, 3'd0, 48'd0);
                    random_count += 2;
                end
            end
            else if (kind == 8)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, 3'd0, 48'd0);
                random_count++;
            end
            else
            begin
                // any lead-class byte followed by any byte at all
                if ($urandom_range(0, 1) == 1)
                    b = 8'($urandom_range(8'h80, 8'h9f));
                else
                    b = 8'($urandom_range(8'he0, 8'hff));
                send_byte(b, 1'b0, 3'd0, 48'd0);
                send_byte(8'($urandom_range(0, 255)), 1'b0, 3'd0, 48'd0);
                random_count += 2;
            end
        end
        din_ch.valid <= 1'b0;

        // drain, then give the block time to show any stray beat
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);
        if (expected_beats.size() != 0)
            note_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));

        $display("sent %0d shift_jis bytes (%0d from the table), checked %0d output beats",
                 items_sent, NumDirected, beats_seen);
        $display("kanji pairs %0d, half-width kana %0d, mismatches %0d",
                 kanji_pairs, kana_bytes, mismatches);
        if (mismatches == 0)
            $display("** shift_jis_to_iso2022jp_unit: PASSED **");
        else
            $display("** shift_jis_to_iso2022jp_unit: FAILED **");
        $finish;
    end

endmodule
